FILE: rtl/hrlp_pkg.sv
// shared types, constants and character helpers for the request line parser
`timescale 1ns / 1ps
`default_nettype none

package hrlp_pkg;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_NO_SPACE    = 3'd1;
    localparam logic [2:0] STATUS_NO_URI      = 3'd2;
    localparam logic [2:0] STATUS_BAD_METHOD  = 3'd3;
    localparam logic [2:0] STATUS_BAD_VERSION = 3'd4;
    localparam logic [2:0] STATUS_TOO_LONG    = 3'd5;

    localparam logic [3:0] NO_METHOD = 4'd8;
    localparam int unsigned METHOD_COUNT = 8;

    localparam logic [15:0] VERSION_MAX = 16'hFFFF;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    // names sit right-justified, first character in the highest used byte
    localparam logic [55:0] METHOD_NAME [METHOD_COUNT] = '{
        "GET", "POST", "HEAD", "OPTIONS", "PUT", "DELETE", "TRACE", "CONNECT"
    };
    localparam logic [2:0] METHOD_LEN [METHOD_COUNT] = '{
        3'd3, 3'd4, 3'd4, 3'd7, 3'd3, 3'd6, 3'd5, 3'd7
    };
    localparam logic [39:0] VERSION_PREFIX = "HTTP/";
    localparam logic [2:0]  PREFIX_LEN     = 3'd5;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  method_code;
        logic [11:0] uri_start;
        logic [12:0] uri_length;
        logic [12:0] page_start;
        logic [15:0] major_version;
        logic [15:0] minor_version;
    } result_t;

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    // character p of method i, valid only for p below the method length
    function automatic logic [7:0] method_char(input logic [2:0] i, input logic [2:0] p);
        logic [2:0] k;
        k = (METHOD_LEN[i] - 3'd1) - p;
        return METHOD_NAME[i][k*8 +: 8];
    endfunction

    function automatic logic [7:0] prefix_char(input logic [2:0] c);
        logic [2:0] k;
        k = (PREFIX_LEN - 3'd1) - c;
        return VERSION_PREFIX[k*8 +: 8];
    endfunction

    // acc * 10 + digit, saturating
    function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] b);
        logic [19:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, b[3:0]};
        return (v > {4'd0, VERSION_MAX}) ? VERSION_MAX : v[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hrlp_in_stage.sv
// input register holding one byte of the request line
`timescale 1ns / 1ps
`default_nettype none

module hrlp_in_stage
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] line_byte,
    input  wire logic       end_of_line,
    input  wire logic       advance,
    output logic            stage_valid,
    output logic [7:0]      stage_byte,
    output logic            stage_eol
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       eol_reg;

    assign in_ready    = !valid_reg || advance;
    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;
    assign stage_eol   = eol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= line_byte;
            eol_reg  <= end_of_line;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hrlp_core.sv
// parse state machine: one byte per cycle while advance is high; result formed on the last byte
`timescale 1ns / 1ps
`default_nettype none

module hrlp_core
#(
    parameter int MAX_LINE = 4096
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [7:0] stage_byte,
    input  wire logic       stage_eol,
    output logic            result_valid,
    output hrlp_pkg::result_t result
);

    localparam int POS_W = $clog2(MAX_LINE + 1);
    localparam int TOT_W = $clog2(MAX_LINE + 2);
    localparam logic [TOT_W-1:0] MAX_T = TOT_W'(MAX_LINE);

    localparam logic [2:0] PH_METHOD = 3'd0;
    localparam logic [2:0] PH_URI    = 3'd1;
    localparam logic [2:0] PH_PREFIX = 3'd2;
    localparam logic [2:0] PH_MAJOR  = 3'd3;
    localparam logic [2:0] PH_MINOR  = 3'd4;
    localparam logic [2:0] PH_TRAIL  = 3'd5;
    localparam logic [2:0] PH_NOVER  = 3'd6;
    localparam logic [2:0] PH_BAD    = 3'd7;

    logic [2:0]       phase_reg,     phase_next;
    logic [POS_W-1:0] pos_reg,       pos_next;
    logic [7:0]       cand_reg,      cand_next;
    logic [POS_W-1:0] uri_begin_reg, uri_begin_next;
    logic [POS_W-1:0] slash_reg,     slash_next;
    logic [15:0]      major_reg,     major_next;
    logic [15:0]      minor_reg,     minor_next;
    logic             digits_reg,    digits_next;
    logic [TOT_W-1:0] total_reg,     total_next;
    logic [2:0]       prefix_reg,    prefix_next;
    logic [POS_W-1:0] uri_end_reg,   uri_end_next;
    logic             closed_reg,    closed_next;
    logic             stopped_reg,   stopped_next;

    logic             take;
    logic [7:0]       ub;
    logic             sp;
    logic             dg;
    logic [2:0]       err;
    logic [2:0]       status;
    logic [3:0]       method;
    logic [POS_W-1:0] uri_stop;

    assign ub = hrlp_pkg::to_upper(stage_byte);
    assign sp = hrlp_pkg::is_space(stage_byte);
    assign dg = hrlp_pkg::is_digit(stage_byte);

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        cand_next      = cand_reg;
        uri_begin_next = uri_begin_reg;
        slash_next     = slash_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        digits_next    = digits_reg;
        prefix_next    = prefix_reg;
        uri_end_next   = uri_end_reg;
        closed_next    = closed_reg;

        total_next   = (total_reg <= MAX_T) ? total_reg + 1'b1 : total_reg;
        stopped_next = stopped_reg || (stage_byte == hrlp_pkg::CHAR_NUL);
        // a nul byte, the bytes after it and bytes past the length limit are only counted
        take = !stopped_next && (total_next <= MAX_T);

        if (take)
        begin
            pos_next = pos_reg + 1'b1;
            unique case (phase_reg) inside
                PH_METHOD:
                begin
                    if (stage_byte == hrlp_pkg::CHAR_SPACE)
                    begin
                        for (int i = 0; i < hrlp_pkg::METHOD_COUNT; i++)
                        begin
                            cand_next[i] = cand_reg[i] &&
                                (pos_reg == POS_W'(hrlp_pkg::METHOD_LEN[i]));
                        end
                        uri_begin_next = pos_reg + 1'b1;
                        slash_next     = pos_reg + 1'b1;
                        phase_next     = PH_URI;
                    end
                    else
                    begin
                        for (int i = 0; i < hrlp_pkg::METHOD_COUNT; i++)
                        begin
                            cand_next[i] = cand_reg[i] &&
                                (pos_reg < POS_W'(hrlp_pkg::METHOD_LEN[i])) &&
                                (ub == hrlp_pkg::method_char(3'(i), pos_reg[2:0]));
                        end
                    end
                end
                PH_URI:
                begin
                    if (stage_byte == hrlp_pkg::CHAR_SPACE)
                    begin
                        uri_end_next = pos_reg;
                        closed_next  = 1'b1;
                        prefix_next  = 3'd0;
                        phase_next   = PH_PREFIX;
                    end
                    else if (stage_byte == hrlp_pkg::CHAR_SLASH)
                    begin
                        slash_next = pos_reg + 1'b1;
                    end
                end
                PH_PREFIX:
                begin
                    if (prefix_reg < hrlp_pkg::PREFIX_LEN &&
                        ub == hrlp_pkg::prefix_char(prefix_reg))
                    begin
                        prefix_next = prefix_reg + 1'b1;
                        if (prefix_reg == hrlp_pkg::PREFIX_LEN - 3'd1)
                        begin
                            major_next  = 16'd0;
                            minor_next  = 16'd0;
                            digits_next = 1'b0;
                            phase_next  = PH_MAJOR;
                        end
                    end
                    else if (prefix_reg == 3'd0 && sp)
                    begin
                        phase_next = PH_NOVER;
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_MAJOR:
                begin
                    if (dg)
                    begin
                        major_next  = hrlp_pkg::add_digit(major_reg, stage_byte);
                        digits_next = 1'b1;
                    end
                    else if (stage_byte == hrlp_pkg::CHAR_DOT && digits_reg)
                    begin
                        digits_next = 1'b0;
                        phase_next  = PH_MINOR;
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_MINOR:
                begin
                    if (dg)
                    begin
                        minor_next  = hrlp_pkg::add_digit(minor_reg, stage_byte);
                        digits_next = 1'b1;
                    end
                    else if (digits_reg && sp)
                    begin
                        phase_next = PH_TRAIL;
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_TRAIL, PH_NOVER:
                begin
                    if (!sp)
                    begin
                        phase_next = PH_BAD;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // result, taken from the state after this byte
    always_comb
    begin
        case (phase_next) inside
            PH_PREFIX: err = (prefix_next == 3'd0) ? hrlp_pkg::STATUS_OK
                                                   : hrlp_pkg::STATUS_BAD_VERSION;
            PH_MAJOR,
            PH_BAD:    err = hrlp_pkg::STATUS_BAD_VERSION;
            PH_MINOR:  err = digits_next ? hrlp_pkg::STATUS_OK
                                         : hrlp_pkg::STATUS_BAD_VERSION;
            default:   err = hrlp_pkg::STATUS_OK;
        endcase

        if (total_next > MAX_T)
            status = hrlp_pkg::STATUS_TOO_LONG;
        else if (phase_next == PH_METHOD)
            status = hrlp_pkg::STATUS_NO_SPACE;
        else if (pos_next <= uri_begin_next)
            status = hrlp_pkg::STATUS_NO_URI;
        else if (cand_next == 8'd0)
            status = hrlp_pkg::STATUS_BAD_METHOD;
        else
            status = err;

        method = hrlp_pkg::NO_METHOD;
        for (int i = hrlp_pkg::METHOD_COUNT - 1; i >= 0; i--)
        begin
            if (cand_next[i])
                method = 4'(i);
        end

        uri_stop = closed_next ? uri_end_next : pos_next;

        result = '0;
        result.status        = status;
        result.method_code   = hrlp_pkg::NO_METHOD;
        result.major_version = 16'd1;
        result.minor_version = 16'd0;
        if (status == hrlp_pkg::STATUS_OK || status == hrlp_pkg::STATUS_BAD_VERSION)
        begin
            result.method_code = method;
            result.uri_start   = 12'(uri_begin_next);
            result.uri_length  = 13'(uri_stop - uri_begin_next);
            result.page_start  = 13'(slash_next);
            if (status == hrlp_pkg::STATUS_OK &&
                (phase_next == PH_MINOR || phase_next == PH_TRAIL))
            begin
                result.major_version = major_next;
                result.minor_version = minor_next;
            end
        end
    end

    assign result_valid = advance && stage_eol;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_METHOD;
            pos_reg       <= '0;
            cand_reg      <= 8'hFF;
            uri_begin_reg <= '0;
            slash_reg     <= '0;
            major_reg     <= 16'd1;
            minor_reg     <= 16'd0;
            digits_reg    <= 1'b0;
            total_reg     <= '0;
            prefix_reg    <= 3'd0;
            uri_end_reg   <= '0;
            closed_reg    <= 1'b0;
            stopped_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (stage_eol)
            begin
                // line done, start over for the next one
                phase_reg     <= PH_METHOD;
                pos_reg       <= '0;
                cand_reg      <= 8'hFF;
                uri_begin_reg <= '0;
                slash_reg     <= '0;
                major_reg     <= 16'd1;
                minor_reg     <= 16'd0;
                digits_reg    <= 1'b0;
                total_reg     <= '0;
                prefix_reg    <= 3'd0;
                uri_end_reg   <= '0;
                closed_reg    <= 1'b0;
                stopped_reg   <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                cand_reg      <= cand_next;
                uri_begin_reg <= uri_begin_next;
                slash_reg     <= slash_next;
                major_reg     <= major_next;
                minor_reg     <= minor_next;
                digits_reg    <= digits_next;
                total_reg     <= total_next;
                prefix_reg    <= prefix_next;
                uri_end_reg   <= uri_end_next;
                closed_reg    <= closed_next;
                stopped_reg   <= stopped_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/http_request_line_parser.sv
// http request line parser: byte stream in, one parse result per line out
//
// input channel: one byte of the request line per transfer on in_valid /
// in_ready, end_of_line set on the final byte. a byte can be taken every
// cycle while in_ready is high.
// output channel: one result per line on out_valid / out_ready with status,
// method, uri offset and length, page offset and the http version.
// output path: the final byte passes the input register, then the parse
// logic into the result register, and out_valid rises with it.
// throughput: one byte per cycle while no final byte waits on a result.
// stalls: while a result waits, non-final bytes of the next line keep
// flowing; the final byte of that line is held in the input register until
// the waiting result is taken, and in_ready is low only while it is held.
// reset: clears the valid flags of both registers and puts the parser at
// the start of a line; parse state also returns there after every result.
`timescale 1ns / 1ps
`default_nettype none

module http_request_line_parser
#(
    parameter int MAX_LINE = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  line_byte,
    input  wire logic        end_of_line,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [3:0]       method_code,
    output logic [11:0]      uri_start,
    output logic [12:0]      uri_length,
    output logic [12:0]      page_start,
    output logic [15:0]      major_version,
    output logic [15:0]      minor_version
);

    logic              stage_valid;
    logic [7:0]        stage_byte;
    logic              stage_eol;
    logic              advance;
    logic              out_free;
    logic              result_valid;
    hrlp_pkg::result_t result;

    logic              out_valid_reg;
    hrlp_pkg::result_t result_reg;

    assign out_free = !out_valid_reg || out_ready;
    // only the final byte needs room in the result register
    assign advance  = stage_valid && (!stage_eol || out_free);

    hrlp_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .line_byte   (line_byte),
        .end_of_line (end_of_line),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte),
        .stage_eol   (stage_eol)
    );

    hrlp_core #(.MAX_LINE(MAX_LINE)) u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .stage_byte   (stage_byte),
        .stage_eol    (stage_eol),
        .result_valid (result_valid),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid)
        begin
            result_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = result_reg.status;
    assign method_code   = result_reg.method_code;
    assign uri_start     = result_reg.uri_start;
    assign uri_length    = result_reg.uri_length;
    assign page_start    = result_reg.page_start;
    assign major_version = result_reg.major_version;
    assign minor_version = result_reg.minor_version;

    // input side only blocks behind a waiting result
    a_ready_low_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg)
        else $error("in_ready low with no result pending");

    // a final byte never overwrites a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !result_valid)
        else $error("result register overwritten");

    a_error_clears_method: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status != hrlp_pkg::STATUS_OK &&
        status != hrlp_pkg::STATUS_BAD_VERSION |->
        method_code == hrlp_pkg::NO_METHOD && uri_length == 13'd0)
        else $error("error result carries method or uri");

    // an empty uri between two spaces is still an ok line
    a_ok_has_method: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status == hrlp_pkg::STATUS_OK |->
        method_code != hrlp_pkg::NO_METHOD)
        else $error("ok result without method");

    a_error_default_version: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status != hrlp_pkg::STATUS_OK |->
        major_version == 16'd1 && minor_version == 16'd0)
        else $error("error result with parsed version");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// self-checking bench for the http request line parser
`timescale 1ns / 1ps

module testbench;

    localparam int    LINE_LIMIT   = 4096;
    localparam int    METHOD_TOTAL = 8;
    localparam int    TAG_LEN      = 5;
    localparam string VERSION_TAG  = "HTTP/";
    localparam int    BYTE_TARGET  = 1450;

    typedef enum logic [3:0] {
        SCAN_METHOD,
        SCAN_URI,
        SCAN_PREFIX,
        SCAN_MAJOR,
        SCAN_MINOR,
        SCAN_TAIL,
        SCAN_NO_VERSION,
        SCAN_BROKEN
    } scan_phase_e;

    typedef enum int {
        VERB_GET,
        VERB_POST,
        VERB_HEAD,
        VERB_OPTIONS,
        VERB_PUT,
        VERB_DELETE,
        VERB_TRACE,
        VERB_CONNECT
    } verb_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  line_byte = 8'd0;
    logic        end_of_line = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [3:0]  method_code;
    logic [11:0] uri_start;
    logic [12:0] uri_length;
    logic [12:0] page_start;
    logic [15:0] major_version;
    logic [15:0] minor_version;

    // parse model state
    scan_phase_e scan;
    int          col;
    logic [7:0]  verb_live;
    int          path_from;
    int          page_from;
    int          path_to;
    logic        path_shut;
    logic [15:0] major_acc;
    logic [15:0] minor_acc;
    logic        got_digit;
    int          seen;
    int          prefix_hits;
    logic        nul_hit;

    hrlp_pkg::result_t results_due[$];
    logic [7:0]        line_buf[$];

    bit          send_steady = 1'b0;
    bit          take_steady = 1'b0;
    int          take_hold = 0;
    int          mismatches = 0;
    int          results_checked = 0;
    int          lines_sent = 0;
    int          bytes_sent = 0;
    int          status_tally[8];

    http_request_line_parser #(
        .MAX_LINE(LINE_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .line_byte(line_byte),
        .end_of_line(end_of_line),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .method_code(method_code),
        .uri_start(uri_start),
        .uri_length(uri_length),
        .page_start(page_start),
        .major_version(major_version),
        .minor_version(minor_version)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("timeout: results still outstanding %0d", results_due.size());
        $display("http_request_line_parser test failed");
        $finish;
    end

    function automatic int draw_gap(input bit steady);
        return steady ? 0 : int'($urandom_range(0, 7));
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        if (b >= "a" && b <= "z")
            return b ^ 8'h20;
        return b;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        case (b) inside
            8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, hrlp_pkg::CHAR_SPACE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [15:0] version_step(input logic [15:0] acc, input logic [7:0] b);
        int v;
        v = int'(acc) * 10 + int'(b) - 48;
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic string verb_text(input verb_e v);
        case (v)
            VERB_GET:     return "GET";
            VERB_POST:    return "POST";
            VERB_HEAD:    return "HEAD";
            VERB_OPTIONS: return "OPTIONS";
            VERB_PUT:     return "PUT";
            VERB_DELETE:  return "DELETE";
            VERB_TRACE:   return "TRACE";
            default:      return "CONNECT";
        endcase
    endfunction

    task automatic clear_parse();
        scan        = SCAN_METHOD;
        col         = 0;
        verb_live   = 8'hFF;
        path_from   = 0;
        page_from   = 0;
        path_to     = 0;
        path_shut   = 1'b0;
        major_acc   = 16'd1;
        minor_acc   = 16'd0;
        got_digit   = 1'b0;
        seen        = 0;
        prefix_hits = 0;
        nul_hit     = 1'b0;
    endtask

    task automatic scan_byte(input logic [7:0] b);
        string name;
        int    i;
        logic  digit;
        digit = (b >= "0" && b <= "9");
        case (scan)
            SCAN_METHOD:
            begin
                for (i = 0; i < METHOD_TOTAL; i++)
                begin
                    name = verb_text(verb_e'(i));
                    if (b == hrlp_pkg::CHAR_SPACE)
                    begin
                        if (name.len() != col)
                            verb_live[i] = 1'b0;
                    end
                    else if (col >= name.len() || fold_case(b) != 8'(name[col]))
                        verb_live[i] = 1'b0;
                end
                if (b == hrlp_pkg::CHAR_SPACE)
                begin
                    path_from = col + 1;
                    page_from = col + 1;
                    scan = SCAN_URI;
                end
            end
            SCAN_URI:
            begin
                if (b == hrlp_pkg::CHAR_SPACE)
                begin
                    path_to = col;
                    path_shut = 1'b1;
                    prefix_hits = 0;
                    scan = SCAN_PREFIX;
                end
                else if (b == hrlp_pkg::CHAR_SLASH)
                    page_from = col + 1;
            end
            SCAN_PREFIX:
            begin
                if (prefix_hits < TAG_LEN && fold_case(b) == 8'(VERSION_TAG[prefix_hits]))
                begin
                    prefix_hits++;
                    if (prefix_hits == TAG_LEN)
                    begin
                        major_acc = 16'd0;
                        minor_acc = 16'd0;
                        got_digit = 1'b0;
                        scan = SCAN_MAJOR;
                    end
                end
                else if (prefix_hits == 0 && is_blank(b))
                    scan = SCAN_NO_VERSION;
                else
                    scan = SCAN_BROKEN;
            end
            SCAN_MAJOR:
            begin
                if (digit)
                begin
                    major_acc = version_step(major_acc, b);
                    got_digit = 1'b1;
                end
                else if (b == hrlp_pkg::CHAR_DOT && got_digit)
                begin
                    got_digit = 1'b0;
                    scan = SCAN_MINOR;
                end
                else
                    scan = SCAN_BROKEN;
            end
            SCAN_MINOR:
            begin
                if (digit)
                begin
                    minor_acc = version_step(minor_acc, b);
                    got_digit = 1'b1;
                end
                else if (got_digit && is_blank(b))
                    scan = SCAN_TAIL;
                else
                    scan = SCAN_BROKEN;
            end
            SCAN_TAIL, SCAN_NO_VERSION:
            begin
                if (!is_blank(b))
                    scan = SCAN_BROKEN;
            end
            default:
            begin
            end
        endcase
        col = col + 1;
    endtask

    // one accepted byte; the last byte of a line queues the parse result
    task automatic predict_byte(input logic [7:0] b, input logic eol);
        hrlp_pkg::result_t r;
        logic [2:0]        late;
        int                i;
        if (seen <= LINE_LIMIT)
            seen++;
        if (b == hrlp_pkg::CHAR_NUL)
            nul_hit = 1'b1;
        if (!nul_hit && seen <= LINE_LIMIT)
            scan_byte(b);
        if (eol)
        begin
            case (scan) inside
                SCAN_PREFIX:
                    late = (prefix_hits == 0) ? hrlp_pkg::STATUS_OK
                                              : hrlp_pkg::STATUS_BAD_VERSION;
                SCAN_MAJOR, SCAN_BROKEN:
                    late = hrlp_pkg::STATUS_BAD_VERSION;
                SCAN_MINOR:
                    late = got_digit ? hrlp_pkg::STATUS_OK : hrlp_pkg::STATUS_BAD_VERSION;
                default:
                    late = hrlp_pkg::STATUS_OK;
            endcase
            if (seen > LINE_LIMIT)
                r.status = hrlp_pkg::STATUS_TOO_LONG;
            else if (scan == SCAN_METHOD)
                r.status = hrlp_pkg::STATUS_NO_SPACE;
            else if (col <= path_from)
                r.status = hrlp_pkg::STATUS_NO_URI;
            else if (verb_live == 8'd0)
                r.status = hrlp_pkg::STATUS_BAD_METHOD;
            else
                r.status = late;
            r.method_code   = hrlp_pkg::NO_METHOD;
            r.uri_start     = 12'd0;
            r.uri_length    = 13'd0;
            r.page_start    = 13'd0;
            r.major_version = 16'd1;
            r.minor_version = 16'd0;
            if (r.status == hrlp_pkg::STATUS_OK || r.status == hrlp_pkg::STATUS_BAD_VERSION)
            begin
                for (i = METHOD_TOTAL - 1; i >= 0; i--)
                    if (verb_live[i])
                        r.method_code = 4'(i);
                r.uri_start  = 12'(path_from);
                r.uri_length = 13'((path_shut ? path_to : col) - path_from);
                r.page_start = 13'(page_from);
                if (r.status == hrlp_pkg::STATUS_OK &&
                    (scan == SCAN_MINOR || scan == SCAN_TAIL))
                begin
                    r.major_version = major_acc;
                    r.minor_version = minor_acc;
                end
            end
            results_due.push_back(r);
            clear_parse();
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_checked, field, got, want));
    endtask

    task automatic check_result();
        hrlp_pkg::result_t want;
        if (results_due.size() == 0)
        begin
            report_mismatch("result with no line outstanding");
            return;
        end
        want = results_due.pop_front();
        results_checked++;
        status_tally[want.status]++;
        check_field("status", 16'(status), 16'(want.status));
        check_field("method_code", 16'(method_code), 16'(want.method_code));
        check_field("uri_start", 16'(uri_start), 16'(want.uri_start));
        check_field("uri_length", 16'(uri_length), 16'(want.uri_length));
        check_field("page_start", 16'(page_start), 16'(want.page_start));
        check_field("major_version", major_version, want.major_version);
        check_field("minor_version", minor_version, want.minor_version);
    endtask

    // result side: after each transfer, hold ready low for a drawn number of valid cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                check_result();
                take_hold = draw_gap(take_steady);
            end
            else if (out_valid && take_hold > 0)
                take_hold--;
            out_ready <= (take_hold == 0);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eol);
        int gap;
        gap = draw_gap(send_steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            line_byte <= 8'($urandom);
            end_of_line <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        line_byte <= b;
        end_of_line <= eol;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_byte(b, eol);
        bytes_sent++;
    endtask

    task automatic ship_line();
        int i;
        for (i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
        lines_sent++;
    endtask

    task automatic push_text(input string s, input bit mixed);
        int         i;
        logic [7:0] c;
        for (i = 0; i < s.len(); i++)
        begin
            c = 8'(s[i]);
            if (mixed && c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1)
                c = c | 8'h20;
            line_buf.push_back(c);
        end
    endtask

    task automatic send_line(input string s);
        push_text(s, 1'b0);
        ship_line();
    endtask

    task automatic push_blanks(input int n);
        int k;
        repeat (n)
        begin
            k = $urandom_range(0, 5);
            line_buf.push_back(k == 5 ? hrlp_pkg::CHAR_SPACE : 8'(9 + k));
        end
    endtask

    task automatic push_number();
        case ($urandom_range(0, 7))
            0: push_text($sformatf("%0d", $urandom_range(0, 999999)), 1'b0);
            1: push_text($sformatf("%05d", $urandom_range(0, 99)), 1'b0);
            default: push_text($sformatf("%0d", $urandom_range(0, 12)), 1'b0);
        endcase
    endtask

    task automatic push_version();
        push_text(VERSION_TAG, 1'b1);
        push_number();
        line_buf.push_back(hrlp_pkg::CHAR_DOT);
        push_number();
    endtask

    // mostly well-formed lines with random content, some noise and broken ones
    task automatic build_random_line();
        int    n;
        int    i;
        int    mark;
        int    pick;
        string name;
        if ($urandom_range(0, 15) == 0)
        begin
            n = $urandom_range(1, 24);
            repeat (n) line_buf.push_back(8'($urandom));
            return;
        end
        pick = $urandom_range(0, 11);
        name = verb_text(verb_e'($urandom_range(0, METHOD_TOTAL - 1)));
        if (pick < METHOD_TOTAL)
            push_text(verb_text(verb_e'(pick)), 1'b1);
        else if (pick == 8)
            push_text(name.substr(0, 1), 1'b1);
        else if (pick == 9)
            push_text({name, "S"}, 1'b1);
        else if (pick == 10)
        begin
            n = $urandom_range(1, 7);
            repeat (n) line_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end
        if ($urandom_range(0, 15) == 0)
            return;
        line_buf.push_back(hrlp_pkg::CHAR_SPACE);
        n = $urandom_range(0, 14);
        repeat (n)
        begin
            pick = $urandom_range(0, 7);
            if (pick < 2)
                line_buf.push_back(hrlp_pkg::CHAR_SLASH);
            else if (pick == 7)
                line_buf.push_back(8'($urandom));
            else
                line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
        case ($urandom_range(0, 11))
            0:
            begin
            end
            1:
            begin
                line_buf.push_back(hrlp_pkg::CHAR_SPACE);
                push_blanks($urandom_range(0, 3));
            end
            2:
            begin
                line_buf.push_back(hrlp_pkg::CHAR_SPACE);
                n = $urandom_range(1, 6);
                repeat (n) line_buf.push_back(8'($urandom));
            end
            3:
            begin
                line_buf.push_back(hrlp_pkg::CHAR_SPACE);
                mark = line_buf.size();
                push_version();
                i = $urandom_range(mark, line_buf.size() - 1);
                if ($urandom_range(0, 1) == 1)
                    line_buf[i] = 8'($urandom);
                else
                    while (line_buf.size() > i + 1)
                        line_buf.delete(line_buf.size() - 1);
            end
            default:
            begin
                line_buf.push_back(hrlp_pkg::CHAR_SPACE);
                push_version();
                push_blanks($urandom_range(0, 3));
            end
        endcase
    endtask

    task automatic test_methods();
        send_line("GET /index.html HTTP/1.1\015\012");
        send_line("post /api/v2/items HTTP/1.0");
        send_line("HeAd / http/2.0\t");
        send_line("OPTIONS * HTTP/1.1");
        send_line("put /a/b/ HTTP/1.1 ");
        send_line("DELETE /x/y/z.txt HTTP/0.9\012");
        send_line("trace /t");
        send_line("CONNECT host:443 HTTP/1.1\015\012");
    endtask

    task automatic test_malformed_lines();
        send_line("GET");
        send_line("GET\t/x HTTP/1.1");
        send_line("GET ");
        send_line(" /x HTTP/1.1");
        send_line("GETS /x HTTP/1.1");
        send_line("PO /x");
    endtask

    task automatic test_versions();
        send_line("GET /a HTTP/99999.123456");
        send_line("GET /a HTTP/007.010 \015\012");
        send_line("GET /a ");
        send_line("GET /a \t\013\014\015\012");
        send_line("GET /a HTTP/1");
        send_line("GET /a HTTP/1.");
        send_line("GET /a HTTP/.1");
        send_line("GET /a HTTP/+1.0");
        send_line("GET /a HTT");
        send_line("GET /a HTTP/1.1 x");
        send_line("GET /a HTTP/1.1x");
    endtask

    // a zero byte ends the text, the rest only counts toward length
    task automatic test_nul_bytes();
        push_text("GET /ab", 1'b0);
        line_buf.push_back(hrlp_pkg::CHAR_NUL);
        push_text("cd HTTP/1.1", 1'b0);
        ship_line();
        line_buf.push_back(hrlp_pkg::CHAR_NUL);
        ship_line();
        push_text("GET / ", 1'b0);
        line_buf.push_back(hrlp_pkg::CHAR_NUL);
        push_text("junk", 1'b0);
        ship_line();
    endtask

    task automatic test_random_lines();
        int made;
        made = 0;
        while (bytes_sent < BYTE_TARGET)
        begin
            if (made % 8 == 0)
            begin
                send_steady = ($urandom_range(0, 3) == 0);
                take_steady = ($urandom_range(0, 3) == 0);
            end
            build_random_line();
            ship_line();
            made++;
        end
        send_steady = 1'b0;
        take_steady = 1'b0;
    endtask

    initial
    begin
        clear_parse();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_methods();
        test_malformed_lines();
        test_versions();
        test_nul_bytes();
        test_random_lines();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("run covered %0d lines of %0d bytes, %0d results compared",
                 lines_sent, bytes_sent, results_checked);
        $display("by status: ok %0d, no space %0d, no uri %0d, bad method %0d,",
                 status_tally[hrlp_pkg::STATUS_OK],
                 status_tally[hrlp_pkg::STATUS_NO_SPACE],
                 status_tally[hrlp_pkg::STATUS_NO_URI],
                 status_tally[hrlp_pkg::STATUS_BAD_METHOD]);
        $display("  bad version %0d, too long %0d",
                 status_tally[hrlp_pkg::STATUS_BAD_VERSION],
                 status_tally[hrlp_pkg::STATUS_TOO_LONG]);
        if (mismatches == 0)
            $display("http_request_line_parser test passed");
        else
            $display("http_request_line_parser test failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/hrlp_pkg.sv
rtl/hrlp_in_stage.sv
rtl/hrlp_core.sv
rtl/http_request_line_parser.sv
bench/testbench.sv
